// ===== src/butp_pkg.sv =====
// Shared types, constants and label merge function for the uniformity tree block.
`default_nettype none

package butp_pkg;

  localparam int unsigned MaxLevels = 10;
  localparam int unsigned LevelW    = $clog2(MaxLevels + 1);
  localparam int unsigned PendIdxW  = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int unsigned PosW      = MaxLevels;
  localparam int unsigned DepthW    = 4;

  localparam logic [DepthW-1:0] DepthReset = DepthW'(3);

  typedef enum logic [1:0] {
    LABEL_B = 2'd0,
    LABEL_I = 2'd1,
    LABEL_F = 2'd2
  } label_e;

  typedef enum logic {
    S_IDLE,
    S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic root;
  } status_t;

  function automatic label_e merge_labels(label_e a, label_e b);
    merge_labels = (a == b && a != LABEL_F) ? a : LABEL_F;
  endfunction

endpackage

`default_nettype wire

// ===== src/butp_datapath.sv =====
// Datapath: depth register, leaf counter, pending left labels and the walking node.
`default_nettype none

module butp_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [butp_pkg::DepthW-1:0]   cfg_data_i,
  input  wire logic                          bit_value_i,
  input  wire butp_pkg::cmd_t                cmd_i,
  output butp_pkg::status_t                  status_o,
  output logic [1:0]                         node_label_o,
  output logic [3:0]                         node_level_o
);

  logic [butp_pkg::DepthW-1:0]  depth_q;
  logic [butp_pkg::PosW-1:0]    leaf_pos_q;
  butp_pkg::label_e             label_q;
  logic [butp_pkg::LevelW-1:0]  level_q;
  logic [butp_pkg::PosW-1:0]    pos_q;
  butp_pkg::label_e             pend_q [butp_pkg::MaxLevels];

  logic [butp_pkg::PendIdxW-1:0] pend_idx;
  logic [butp_pkg::DepthW-1:0]   depth_clamped;

  assign pend_idx = butp_pkg::PendIdxW'(level_q - butp_pkg::LevelW'(1));
  assign depth_clamped = (cfg_data_i > butp_pkg::DepthW'(butp_pkg::MaxLevels))
                         ? butp_pkg::DepthW'(butp_pkg::MaxLevels) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= butp_pkg::DepthReset;
      leaf_pos_q <= '0;
    end else if (cfg_we_i) begin
      // A new depth restarts the string.
      depth_q    <= depth_clamped;
      leaf_pos_q <= '0;
    end else if (cmd_i.finish) begin
      leaf_pos_q <= status_o.root ? '0 : butp_pkg::PosW'(leaf_pos_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      label_q <= bit_value_i ? butp_pkg::LABEL_I : butp_pkg::LABEL_B;
      level_q <= butp_pkg::LevelW'(depth_q);
      pos_q   <= leaf_pos_q;
    end else if (cmd_i.step) begin
      // Climb one level: combine with the waiting left sibling.
      label_q <= butp_pkg::merge_labels(pend_q[pend_idx], label_q);
      level_q <= level_q - butp_pkg::LevelW'(1);
      pos_q   <= pos_q >> 1;
    end
  end

  // Park a finished left child until its right sibling arrives.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && !status_o.root) begin
      pend_q[pend_idx] <= label_q;
    end
  end

  assign status_o.root = (level_q == '0);
  assign status_o.last = status_o.root || !pos_q[0];

  assign node_label_o = label_q;
  assign node_level_o = 4'(level_q);

  a_step_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !status_o.root)
    else $error("step requested at the root");

  a_step_climbs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> level_q == $past(level_q) - butp_pkg::LevelW'(1))
    else $error("step did not climb one level");

  a_load_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> level_q <= butp_pkg::LevelW'(butp_pkg::MaxLevels))
    else $error("walk started above the maximum depth");

endmodule

`default_nettype wire

// ===== src/butp_ctrl.sv =====
// Controller: accepts a bit, then hands out one node label per cycle up the tree while out_ready_i is high.
`default_nettype none

module butp_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire butp_pkg::status_t  status_i,
  output butp_pkg::cmd_t          cmd_o
);

  butp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= butp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      butp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = butp_pkg::S_OUT;
        end
      end
      butp_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            cmd_o.finish = 1'b1;
            state_d      = butp_pkg::S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: state_d = butp_pkg::S_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output active together");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted request did not produce a result");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && status_i.last) |=> in_ready_o)
    else $error("block not free after the last result");

endmodule

`default_nettype wire

// ===== src/binary_uniformity_tree_postorder_unit.sv =====
// Top level of the binary uniformity tree post-order labeller.
`default_nettype none

// Takes one string bit per request, leftmost first, and returns the post-order
// labels of the complete binary tree over a string of 2^depth bits: the leaf
// label (B for 0, I for 1), then one label per ancestor that the bit completes,
// with run_last on the final one and tree_done on the root. A new bit is accepted
// only after the previous bit's last result is taken; the single output register
// walks up one level per cycle while out_ready_i is high. Depth is written on
// the cfg port (values above 10 act as 10); the user must write it only while
// the block is idle, which it does not enforce; a write restarts the string.
module binary_uniformity_tree_postorder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        bit_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       node_label_o,
  output logic [3:0]       node_level_o,
  output logic             run_last_o,
  output logic             tree_done_o
);

  butp_pkg::cmd_t    cmd;
  butp_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  butp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  butp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .bit_value_i  (bit_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .node_label_o (node_label_o),
    .node_level_o (node_level_o)
  );

  assign run_last_o  = status.last;
  assign tree_done_o = status.root;

endmodule

`default_nettype wire
